/* rtl/core/pme_pkg.sv */
// shared types and constants of the programmable mealy engine
// op and status codes, transition entry layout, result record; no dependencies
`timescale 1ns / 1ps

package pme_pkg;

    localparam int NUM_STATES_DEF = 32;
    localparam int MAX_TRANS_DEF  = 8;
    localparam int STATE_W        = 5;
    localparam int SYM_W          = 8;
    localparam int OP_W           = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_BEGIN  = 3'd1,
        OP_SYMBOL = 3'd2,
        OP_END    = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOTRANS = 3'd1,
        ST_ACCEPT  = 3'd2,
        ST_REJECT  = 3'd3,
        ST_FULL    = 3'd4,
        ST_IGNORED = 3'd5
    } status_t;

    // one stored transition
    typedef struct packed {
        logic               none;
        logic [SYM_W-1:0]   code;
        logic [STATE_W-1:0] dst;
        logic [SYM_W-1:0]   sym;
    } entry_t;

    // one result record
    typedef struct packed {
        logic               emit;
        logic [SYM_W-1:0]   out_symbol;
        logic [STATE_W-1:0] state_now;
        status_t            status;
    } res_t;

endpackage

/* rtl/core/pme_trans_ram.sv */
// transition table storage: one write port, one registered read port
// depends on pme_pkg for the entry layout
`timescale 1ns / 1ps

module pme_trans_ram #(
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  pme_pkg::entry_t   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output pme_pkg::entry_t   rd_data
);
    import pme_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/programmable_mealy_engine_top.sv */
// top level of the programmable mealy engine: request sequencer, count
// flops, config registers; depends on pme_pkg and pme_trans_ram
//
//   channel   direction  handshake            payload
//   s_*       in         s_valid / s_ready    op, from_state, symbol, to_state,
//                                             out_code, out_none
//   m_*       out        m_valid / m_ready    emit, out_symbol, state_now, status
//   apb       in         psel/penable/pwrite  paddr (0 initial_state, 4 final_mask)
//
// a symbol request keeps ready low while it scans the n entries of the current
// state's list and until its result leaves HOLD for the output register, n being
// the list length (at most MAX_TRANS); the single read port of the table ram
// delivers one entry per cycle and one shared comparator checks it against the
// symbol. every other request keeps ready low only until its result leaves HOLD.
// reset (aresetn low, synchronous) clears counts, state, rejection and registers;
// table contents are not cleared. a stalled result sits in the output register
// while the next request is accepted; a second finished result waits in HOLD.
`timescale 1ns / 1ps

module programmable_mealy_engine_top #(
    parameter int NUM_STATES = pme_pkg::NUM_STATES_DEF,
    parameter int MAX_TRANS  = pme_pkg::MAX_TRANS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [4:0]  s_from_state,
    input  logic [7:0]  s_symbol,
    input  logic [4:0]  s_to_state,
    input  logic [7:0]  s_out_code,
    input  logic        s_out_none,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_emit,
    output logic [7:0]  m_out_symbol,
    output logic [4:0]  m_state_now,
    output logic [2:0]  m_status,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pme_pkg::*;

    localparam int SI_W      = $clog2(NUM_STATES);
    localparam int CNT_W     = $clog2(MAX_TRANS + 1);
    localparam int IDX_W     = (MAX_TRANS > 1) ? $clog2(MAX_TRANS) : 1;
    localparam int ADDR_W    = SI_W + IDX_W;
    localparam int CNT_DEPTH = 1 << SI_W;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        HOLD
    } fsm_t;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    fsm_t                fsm_reg, fsm_next;
    logic [STATE_W-1:0]  cur_reg, cur_next;
    logic                rej_reg, rej_next;
    logic [STATE_W-1:0]  initial_reg;
    logic [31:0]         final_mask_reg;
    logic [CNT_W-1:0]    cnt_reg [CNT_DEPTH];

    // scan working registers
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                pend_reg, pend_next;
    logic                found_reg, found_next;
    entry_t              hit_reg, hit_next;

    // finished result and output register
    res_t                res_reg, res_next;
    res_t                out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // table ram and count lookup
    // ------------------------------------------------------------------
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    entry_t              wr_data;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    entry_t              rd_data;

    logic                cnt_inc;
    logic                cnt_clr;
    logic [SI_W-1:0]     cnt_idx;
    logic [CNT_W-1:0]    cnt_rd;
    logic                from_ok, to_ok, cur_ok;
    logic                match;
    logic                found_now;
    entry_t              hit_now;

    pme_trans_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one count read per cycle: symbol steps look at the current state,
    // everything else at the request's source state
    assign cnt_idx = (op_t'(s_op) == OP_SYMBOL) ? SI_W'(cur_reg) : SI_W'(s_from_state);
    assign cnt_rd  = cnt_reg[cnt_idx];

    assign from_ok = int'(s_from_state) < NUM_STATES;
    assign to_ok   = int'(s_to_state) < NUM_STATES;
    assign cur_ok  = int'(cur_reg) < NUM_STATES;

    // new entry goes to the tail of its source list
    assign wr_addr      = {SI_W'(s_from_state), cnt_rd[IDX_W-1:0]};
    assign wr_data.sym  = s_symbol;
    assign wr_data.dst  = s_to_state;
    assign wr_data.code = s_out_code;
    assign wr_data.none = s_out_none;

    assign rd_addr = {SI_W'(cur_reg), k_reg[IDX_W-1:0]};

    // shared comparator: entry read last cycle against the word symbol
    assign match     = pend_reg && (rd_data.sym == sym_reg);
    assign found_now = found_reg || match;
    assign hit_now   = match ? rd_data : hit_reg;

    assign s_ready = (fsm_reg == IDLE);

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        fsm_next     = fsm_reg;
        cur_next     = cur_reg;
        rej_next     = rej_reg;
        sym_next     = sym_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        pend_next    = 1'b0;
        found_next   = found_reg;
        hit_next     = hit_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        cnt_inc      = 1'b0;
        cnt_clr      = 1'b0;

        unique case (fsm_reg)
            IDLE: begin
                if (s_valid) begin
                    sym_next            = s_symbol;
                    res_next            = '0;
                    res_next.state_now  = cur_reg;
                    res_next.status     = ST_OK;
                    fsm_next            = HOLD;
                    unique case (op_t'(s_op))
                        OP_ADD: begin
                            if (!from_ok || !to_ok) begin
                                res_next.status = ST_IGNORED;
                            end else if (int'(cnt_rd) >= MAX_TRANS) begin
                                res_next.status = ST_FULL;
                            end else begin
                                wr_en   = 1'b1;
                                cnt_inc = 1'b1;
                            end
                        end
                        OP_BEGIN: begin
                            cur_next           = initial_reg;
                            rej_next           = 1'b0;
                            res_next.state_now = initial_reg;
                        end
                        OP_SYMBOL: begin
                            if (rej_reg) begin
                                res_next.status = ST_IGNORED;
                            end else begin
                                // out-of-range state scans an empty list
                                n_next     = cur_ok ? cnt_rd : '0;
                                k_next     = '0;
                                found_next = 1'b0;
                                fsm_next   = SCAN;
                            end
                        end
                        OP_END: begin
                            if (!rej_reg && final_mask_reg[cur_reg]) begin
                                res_next.status = ST_ACCEPT;
                            end else begin
                                rej_next        = 1'b1;
                                res_next.status = ST_REJECT;
                            end
                        end
                        OP_CLEAR: begin
                            cnt_clr = 1'b1;
                        end
                        default: begin
                            res_next.status = ST_IGNORED;
                        end
                    endcase
                end
            end
            SCAN: begin
                found_next = found_now;
                hit_next   = hit_now;
                if (k_reg < n_reg) begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    k_next    = k_reg + 1'b1;
                end else begin
                    // last read has been compared: the latest match wins
                    if (found_now) begin
                        cur_next            = hit_now.dst;
                        res_next.emit       = !hit_now.none;
                        res_next.out_symbol = hit_now.none ? '0 : hit_now.code;
                        res_next.state_now  = hit_now.dst;
                        res_next.status     = ST_OK;
                    end else begin
                        rej_next            = 1'b1;
                        res_next.emit       = 1'b0;
                        res_next.out_symbol = '0;
                        res_next.state_now  = cur_reg;
                        res_next.status     = ST_NOTRANS;
                    end
                    fsm_next = HOLD;
                end
            end
            HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    fsm_next     = IDLE;
                end
            end
            default: begin
                fsm_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= IDLE;
            cur_reg     <= '0;
            rej_reg     <= 1'b0;
            k_reg       <= '0;
            n_reg       <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            cur_reg     <= cur_next;
            rej_reg     <= rej_next;
            k_reg       <= k_next;
            n_reg       <= n_next;
            pend_reg    <= pend_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        sym_reg <= sym_next;
        hit_reg <= hit_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // per-state list lengths, cleared together by reset or clear table
    always_ff @(posedge aclk) begin
        if (!aresetn || cnt_clr) begin
            for (int i = 0; i < CNT_DEPTH; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (cnt_inc) begin
            cnt_reg[cnt_idx] <= cnt_rd + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_reg    <= '0;
            final_mask_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2]) begin
                final_mask_reg <= pwdata;
            end else begin
                initial_reg <= pwdata[STATE_W-1:0];
            end
        end
    end

    assign prdata = paddr[2] ? final_mask_reg : {{(32-STATE_W){1'b0}}, initial_reg};
    assign pready = 1'b1;

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign m_valid      = m_valid_reg;
    assign m_emit       = out_reg.emit;
    assign m_out_symbol = out_reg.out_symbol;
    assign m_state_now  = out_reg.state_now;
    assign m_status     = out_reg.status;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("sequencer ready right after taking a request");

    a_emit_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_emit) |-> (m_status == ST_OK))
        else $error("output symbol emitted with non-ok status");

    a_quiet_symbol: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_emit) |-> (m_out_symbol == '0))
        else $error("output symbol nonzero without emit");

    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == SCAN) |-> ((k_reg <= n_reg) && (int'(n_reg) <= MAX_TRANS)))
        else $error("scan index beyond list length");

    a_scan_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == SCAN && k_reg == n_reg) |=> (fsm_reg == HOLD))
        else $error("scan did not finish after the last entry");

endmodule
